/* src/packed_sorted_key_search_macros.svh */
// assertion macros for the packed sorted key search block
`ifndef PACKED_SORTED_KEY_SEARCH_MACROS_SVH
`define PACKED_SORTED_KEY_SEARCH_MACROS_SVH

// checked only outside reset
`define PKS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PKS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pks_pkg.sv */
// shared constants and types for the packed sorted key search block
package pks_pkg;

  localparam int BUCKET_W         = 64;
  localparam int KEY_W            = 16;
  localparam int KB_W             = 5;
  localparam int POS_W            = 5;

  localparam int WORD_BITS_DEF    = 64;
  localparam int MIN_KEY_BITS_DEF = 4;
  localparam int MAX_KEY_BITS_DEF = 16;

  typedef struct packed {
    logic match;
    logic stop;
  } lane_res_t;

endpackage

/* src/pks_if.sv */
// valid/ready channel interfaces for search beats and result beats
interface pks_in_if;
  import pks_pkg::*;

  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket_word;
  logic [KEY_W-1:0]    search_key;
  logic [KB_W-1:0]     key_bits;

  modport source (output valid, bucket_word, search_key, key_bits, input ready);
  modport sink   (input valid, bucket_word, search_key, key_bits, output ready);
endinterface

interface pks_out_if;
  import pks_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  logic             bucket_empty;

  modport source (output valid, found, position, bucket_empty, input ready);
  modport sink   (input valid, found, position, bucket_empty, output ready);
endinterface

/* src/pks_lane.sv */
// one slot lane: picks its slot for the active key width and compares it
module pks_lane #(
  parameter int LANE         = 0,
  parameter int WORD_BITS    = pks_pkg::WORD_BITS_DEF,
  parameter int MIN_KEY_BITS = pks_pkg::MIN_KEY_BITS_DEF,
  parameter int MAX_KEY_BITS = pks_pkg::MAX_KEY_BITS_DEF
) (
  input  logic [WORD_BITS-1:0]    bucket,
  input  logic [pks_pkg::KB_W-1:0] kb,
  input  logic [MAX_KEY_BITS-1:0] key,
  output pks_pkg::lane_res_t      res
);
  import pks_pkg::*;

  localparam int NK = MAX_KEY_BITS - MIN_KEY_BITS + 1;

  logic [MAX_KEY_BITS-1:0] cand [NK];
  logic [NK-1:0]           cand_ok;
  logic [MAX_KEY_BITS-1:0] slot;
  logic                    slot_ok;
  logic                    zero_end;

  for (genvar g = 0; g < NK; g++) begin : g_width
    localparam int K = MIN_KEY_BITS + g;
    if ((LANE + 1) * K <= WORD_BITS) begin : g_in
      assign cand[g]    = MAX_KEY_BITS'(bucket[LANE*K +: K]);
      assign cand_ok[g] = 1'b1;
    end else begin : g_out
      assign cand[g]    = '0;
      assign cand_ok[g] = 1'b0;
    end
  end

  always_comb begin
    slot    = '0;
    slot_ok = 1'b0;
    for (int g = 0; g < NK; g++) begin
      if (kb == KB_W'(MIN_KEY_BITS + g)) begin
        slot    = cand[g];
        slot_ok = cand_ok[g];
      end
    end
  end

  // a zero slot past slot 0 ends the list
  assign zero_end  = (LANE != 0) && (slot == '0);
  assign res.match = slot_ok && (slot == key);
  assign res.stop  = !slot_ok || (slot == key) || zero_end || (slot > key);

endmodule

/* src/pks_merge.sv */
// merge: first lane that stops the scan gives found and position; an empty bucket gives no hit and position 0
module pks_merge #(
  parameter int NLANES = pks_pkg::WORD_BITS_DEF / pks_pkg::MIN_KEY_BITS_DEF
) (
  input  pks_pkg::lane_res_t        res [NLANES],
  input  logic                      empty,
  output logic                      found,
  output logic [pks_pkg::POS_W-1:0] position
);
  import pks_pkg::*;

  localparam int IDX_W = $clog2(NLANES + 1);

  logic             hit;
  logic             hit_match;
  logic [IDX_W-1:0] idx;

  always_comb begin
    hit       = 1'b0;
    hit_match = 1'b0;
    idx       = IDX_W'(NLANES);
    for (int i = 0; i < NLANES; i++) begin
      if (!hit && res[i].stop) begin
        hit       = 1'b1;
        hit_match = res[i].match;
        idx       = IDX_W'(i);
      end
    end
  end

  assign found    = !empty && hit_match;
  assign position = empty ? '0 : POS_W'(idx);

endmodule

/* src/packed_sorted_key_search.sv */
// top level of the packed sorted key search block
//
//  channel | dir | beat fields                              | handshake
//  in_ch   | in  | bucket_word[64], search_key[16], key_bits[5] | valid/ready
//  out_ch  | out | found[1], position[5], bucket_empty[1]    | valid/ready
//
// one search beat accepted per cycle while the lane stage can advance (in_ch.ready)
// the result passes through the lane stage register and then the output register
// synchronous active-low reset clears both valid flags, no state otherwise
// a stalled output holds its beat, the lane stage moves whenever the output frees
module packed_sorted_key_search #(
  parameter int WORD_BITS    = pks_pkg::WORD_BITS_DEF,
  parameter int MIN_KEY_BITS = pks_pkg::MIN_KEY_BITS_DEF,
  parameter int MAX_KEY_BITS = pks_pkg::MAX_KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pks_in_if.sink    in_ch,
  pks_out_if.source out_ch
);
  import pks_pkg::*;

  localparam int NLANES = WORD_BITS / MIN_KEY_BITS;

  logic [WORD_BITS-1:0]    word;
  logic                    empty;
  logic [KB_W-1:0]         kbc;
  logic [MAX_KEY_BITS:0]   kmask;
  logic [MAX_KEY_BITS-1:0] key;
  lane_res_t               lane_res [NLANES];

  lane_res_t               s1_res_r [NLANES];
  logic                    s1_empty_r;
  logic                    s1_valid_r;
  logic                    s1_valid_nxt;

  logic                    m_found;
  logic [POS_W-1:0]        m_pos;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic                    out_found_r;
  logic [POS_W-1:0]        out_pos_r;
  logic                    out_empty_r;

  logic                    out_adv;
  logic                    s1_adv;

  assign word  = in_ch.bucket_word[WORD_BITS-1:0];
  assign empty = &word;

  // key width clamped to the supported range
  always_comb begin
    if (in_ch.key_bits < KB_W'(MIN_KEY_BITS)) begin
      kbc = KB_W'(MIN_KEY_BITS);
    end else if (in_ch.key_bits > KB_W'(MAX_KEY_BITS)) begin
      kbc = KB_W'(MAX_KEY_BITS);
    end else begin
      kbc = in_ch.key_bits;
    end
  end

  assign kmask = ((MAX_KEY_BITS+1)'(1) << kbc) - (MAX_KEY_BITS+1)'(1);
  assign key   = in_ch.search_key[MAX_KEY_BITS-1:0] & kmask[MAX_KEY_BITS-1:0];

  for (genvar l = 0; l < NLANES; l++) begin : g_lane
    pks_lane #(
      .LANE         (l),
      .WORD_BITS    (WORD_BITS),
      .MIN_KEY_BITS (MIN_KEY_BITS),
      .MAX_KEY_BITS (MAX_KEY_BITS)
    ) u_lane (
      .bucket (word),
      .kb     (kbc),
      .key    (key),
      .res    (lane_res[l])
    );
  end

  // stage handshake
  assign out_adv      = !out_valid_r || out_ch.ready;
  assign s1_adv       = !s1_valid_r || out_adv;
  assign in_ch.ready  = s1_adv;
  assign s1_valid_nxt = s1_adv ? in_ch.valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_res_r   <= lane_res;
      s1_empty_r <= empty;
    end
  end

  pks_merge #(
    .NLANES (NLANES)
  ) u_merge (
    .res      (s1_res_r),
    .empty    (s1_empty_r),
    .found    (m_found),
    .position (m_pos)
  );

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_found_r <= m_found;
      out_pos_r   <= m_pos;
      out_empty_r <= s1_empty_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.position     = out_pos_r;
  assign out_ch.bucket_empty = out_empty_r;

endmodule

/* src/pks_checker.sv */
// port-level assertions for the packed sorted key search block, with bind
`include "packed_sorted_key_search_macros.svh"

module pks_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_found,
  input logic [pks_pkg::POS_W-1:0] out_position,
  input logic                      out_bucket_empty
);
  import pks_pkg::*;

  `PKS_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid, "output valid after reset")

  `PKS_ASSERT(a_stall_holds_valid, clk, rst_n, out_valid && !out_ready |=> out_valid, "output beat dropped while stalled")

  `PKS_ASSERT(a_stall_holds_beat, clk, rst_n, out_valid && !out_ready |=> $stable(out_found) && $stable(out_position) && $stable(out_bucket_empty), "output beat changed while stalled")

  `PKS_ASSERT(a_empty_result, clk, rst_n, out_valid && out_bucket_empty |-> !out_found && out_position == '0, "empty bucket gave a hit or a nonzero position")

endmodule

bind packed_sorted_key_search pks_checker u_pks_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_found        (out_ch.found),
  .out_position     (out_ch.position),
  .out_bucket_empty (out_ch.bucket_empty)
);
